[src/efd_pkg.sv]
// ----------------------------------------------------------------------------
// efd_pkg
// Shared types, register indexes, status codes and the CRC-16 byte update
// for the escaped frame deframer.
// ----------------------------------------------------------------------------
package efd_pkg;

   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 16;

   typedef logic [CsrIdxWidth-1:0] csr_idx_type;

   localparam csr_idx_type CSR_START_BYTE  = 2'd0;
   localparam csr_idx_type CSR_ESCAPE_BYTE = 2'd1;
   localparam csr_idx_type CSR_MAX_LEN     = 2'd2;

   localparam logic [7:0]  START_BYTE_RST  = 8'h7E;
   localparam logic [7:0]  ESCAPE_BYTE_RST = 8'h7D;
   localparam logic [15:0] MAX_LEN_RST     = 16'd253;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_CRC_BAD = 2'd1;
   localparam status_type STATUS_ESC_BAD = 2'd2;
   localparam status_type STATUS_LEN_BAD = 2'd3;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef enum logic [3:0] {
      PH_WAIT       = 4'd0,
      PH_TYPE       = 4'd1,
      PH_SEQ        = 4'd2,
      PH_LEN_LO     = 4'd3,
      PH_LEN_HI     = 4'd4,
      PH_DATA       = 4'd5,
      PH_DATA_ESC   = 4'd6,
      PH_CRC_LO     = 4'd7,
      PH_CRC_LO_ESC = 4'd8,
      PH_CRC_HI     = 4'd9,
      PH_CRC_HI_ESC = 4'd10
   } phase_type;

   // reflected crc-16, one byte, bit at a time unrolled
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[src/efd_req_if.sv]
// ----------------------------------------------------------------------------
// efd_req_if
// Received line byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface efd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

[src/efd_rsp_if.sv]
// ----------------------------------------------------------------------------
// efd_rsp_if
// Result channel: payload bytes and frame-end status, valid/ready handshake.
// ----------------------------------------------------------------------------
interface efd_rsp_if;
   logic        valid;
   logic        ready;
   logic        out_kind;
   logic [7:0]  data_byte;
   logic [1:0]  frame_status;
   logic [7:0]  frame_type;
   logic [7:0]  frame_seq;
   logic [15:0] frame_length;

   modport source (output valid, output out_kind, output data_byte, output frame_status,
                   output frame_type, output frame_seq, output frame_length, input ready);
   modport sink   (input valid, input out_kind, input data_byte, input frame_status,
                   input frame_type, input frame_seq, input frame_length, output ready);
endinterface

[src/efd_csr_if.sv]
// ----------------------------------------------------------------------------
// efd_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface efd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[src/escaped_frame_deframer_crc16.sv]
// ----------------------------------------------------------------------------
// escaped_frame_deframer_crc16
// Byte-stuffed frame deframer with CRC-16/Modbus check: forwards unescaped
// payload bytes and closes each frame with a status beat.
// ----------------------------------------------------------------------------
// output: a result beat shows in the cycle after its line byte is accepted
// throughput: one line byte per cycle unless the result is stalled; parser
//   state, byte-wide crc update combinational; result register frees the input
// reset: synchronous; parser waits for start, crc all ones, registers at
//   their defaults, no result pending
module escaped_frame_deframer_crc16 (
   input  logic       clock,
   input  logic       reset,
   efd_req_if.sink    req_bus,
   efd_rsp_if.source  rsp_bus,
   efd_csr_if.sink    csr_bus
);
   import efd_pkg::*;

   logic [7:0]  start_byte_ff;
   logic [7:0]  escape_byte_ff;
   logic [15:0] max_len_ff;

   phase_type   phase_ff, phase_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  seq_ff, seq_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;

   logic        rsp_valid_ff;
   logic        kind_ff, kind_in;
   logic [7:0]  data_ff, data_in;
   logic [1:0]  status_ff, status_in;
   logic [7:0]  otype_ff, otype_in;
   logic [7:0]  oseq_ff, oseq_in;
   logic [15:0] olen_ff, olen_in;
   logic        emit;

   logic        req_fire;
   logic [7:0]  b;
   logic        is_start, is_esc, lit;
   logic [15:0] crc_upd;
   logic [15:0] rem_dec;
   logic [15:0] len_full;
   logic        crc_match;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign b         = req_bus.rx_byte;
   assign is_start  = (b == start_byte_ff);
   assign is_esc    = (b == escape_byte_ff);
   assign lit       = is_start || is_esc;
   assign crc_upd   = crc16_byte(crc_ff, b);
   assign rem_dec   = (rem_ff != 16'd0) ? rem_ff - 16'd1 : 16'd0;
   assign len_full  = {b, len_ff[7:0]};
   assign crc_match = ({b, crc_lo_ff} == crc_ff);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_WAIT: begin
            if (is_start) phase_in = PH_TYPE;
         end
         PH_TYPE:   phase_in = PH_SEQ;
         PH_SEQ:    phase_in = PH_LEN_LO;
         PH_LEN_LO: phase_in = PH_LEN_HI;
         PH_LEN_HI: begin
            if (len_full > max_len_ff)      phase_in = PH_WAIT;
            else if (len_full == 16'd0)     phase_in = PH_CRC_LO;
            else                            phase_in = PH_DATA;
         end
         PH_DATA: begin
            if (is_esc)                     phase_in = PH_DATA_ESC;
            else if (rem_dec == 16'd0)      phase_in = PH_CRC_LO;
            else                            phase_in = PH_DATA;
         end
         PH_DATA_ESC: begin
            if (!lit)                       phase_in = PH_WAIT;
            else if (rem_dec == 16'd0)      phase_in = PH_CRC_LO;
            else                            phase_in = PH_DATA;
         end
         PH_CRC_LO: begin
            phase_in = is_esc ? PH_CRC_LO_ESC : PH_CRC_HI;
         end
         PH_CRC_LO_ESC: begin
            phase_in = lit ? PH_CRC_HI : PH_WAIT;
         end
         PH_CRC_HI: begin
            phase_in = is_esc ? PH_CRC_HI_ESC : PH_WAIT;
         end
         PH_CRC_HI_ESC: phase_in = PH_WAIT;
         default:       phase_in = PH_WAIT;
      endcase
   end

   // datapath and result beat
   always_comb begin
      type_in   = type_ff;
      seq_in    = seq_ff;
      len_in    = len_ff;
      rem_in    = rem_ff;
      crc_in    = crc_ff;
      crc_lo_in = crc_lo_ff;
      emit      = 1'b0;
      kind_in   = KIND_DATA;
      data_in   = 8'h00;
      status_in = STATUS_OK;
      otype_in  = 8'h00;
      oseq_in   = 8'h00;
      olen_in   = 16'd0;
      unique case (phase_ff) inside
         PH_WAIT: begin
            if (is_start) crc_in = CRC_INIT;
         end
         PH_TYPE: begin
            type_in = b;
            crc_in  = crc_upd;
         end
         PH_SEQ: begin
            seq_in = b;
            crc_in = crc_upd;
         end
         PH_LEN_LO: begin
            len_in = {8'h00, b};
            crc_in = crc_upd;
         end
         PH_LEN_HI: begin
            len_in = len_full;
            rem_in = len_full;
            crc_in = crc_upd;
            if (len_full > max_len_ff) begin
               emit      = 1'b1;
               kind_in   = KIND_END;
               status_in = STATUS_LEN_BAD;
               otype_in  = type_ff;
               oseq_in   = seq_ff;
               olen_in   = len_full;
            end
         end
         PH_DATA, PH_DATA_ESC: begin
            if ((phase_ff == PH_DATA) && is_esc) begin
               emit = 1'b0;
            end else if ((phase_ff == PH_DATA_ESC) && !lit) begin
               emit      = 1'b1;
               kind_in   = KIND_END;
               status_in = STATUS_ESC_BAD;
               otype_in  = type_ff;
               oseq_in   = seq_ff;
               olen_in   = len_ff;
            end else begin
               crc_in  = crc_upd;
               rem_in  = rem_dec;
               emit    = 1'b1;
               data_in = b;
            end
         end
         PH_CRC_LO: begin
            if (!is_esc) crc_lo_in = b;
         end
         PH_CRC_LO_ESC: begin
            if (lit) begin
               crc_lo_in = b;
            end else begin
               emit      = 1'b1;
               kind_in   = KIND_END;
               status_in = STATUS_ESC_BAD;
               otype_in  = type_ff;
               oseq_in   = seq_ff;
               olen_in   = len_ff;
            end
         end
         PH_CRC_HI, PH_CRC_HI_ESC: begin
            if (!((phase_ff == PH_CRC_HI) && is_esc)) begin
               emit     = 1'b1;
               kind_in  = KIND_END;
               otype_in = type_ff;
               oseq_in  = seq_ff;
               olen_in  = len_ff;
               if ((phase_ff == PH_CRC_HI_ESC) && !lit) begin
                  status_in = STATUS_ESC_BAD;
               end else begin
                  status_in = crc_match ? STATUS_OK : STATUS_CRC_BAD;
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff  <= START_BYTE_RST;
         escape_byte_ff <= ESCAPE_BYTE_RST;
         max_len_ff     <= MAX_LEN_RST;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            CSR_START_BYTE:  start_byte_ff  <= csr_bus.data[7:0];
            CSR_ESCAPE_BYTE: escape_byte_ff <= csr_bus.data[7:0];
            CSR_MAX_LEN:     max_len_ff     <= csr_bus.data;
            default: begin
               max_len_ff <= max_len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         type_ff   <= 8'h00;
         seq_ff    <= 8'h00;
         len_ff    <= 16'd0;
         rem_ff    <= 16'd0;
         crc_ff    <= CRC_INIT;
         crc_lo_ff <= 8'h00;
      end else if (req_fire) begin
         phase_ff  <= phase_in;
         type_ff   <= type_in;
         seq_ff    <= seq_in;
         len_ff    <= len_in;
         rem_ff    <= rem_in;
         crc_ff    <= crc_in;
         crc_lo_ff <= crc_lo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         kind_ff   <= kind_in;
         data_ff   <= data_in;
         status_ff <= status_in;
         otype_ff  <= otype_in;
         oseq_ff   <= oseq_in;
         olen_ff   <= olen_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_kind     = kind_ff;
   assign rsp_bus.data_byte    = data_ff;
   assign rsp_bus.frame_status = status_ff;
   assign rsp_bus.frame_type   = otype_ff;
   assign rsp_bus.frame_seq    = oseq_ff;
   assign rsp_bus.frame_length = olen_ff;

endmodule
